// ===== rtl/tsrw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsrw_pkg
// Shared types, tables and helpers for the tri-axial spectrum rotation and
// whole-body weighting block.
// ----------------------------------------------------------------------------
package tsrw_pkg;

  localparam int unsigned CompW      = 24;
  localparam int unsigned BinW       = 9;
  localparam int unsigned CoefW      = 16;
  localparam int unsigned ProdW      = CompW + CoefW;
  localparam int unsigned NumBands   = 23;
  localparam int unsigned BandW      = 5;
  localparam logic [BinW-1:0] TopWeightedBin = 9'd386;

  // Reset values of the angle registers (Q1.15).
  localparam logic signed [CoefW-1:0] CosReset = 16'sd32767;
  localparam logic signed [CoefW-1:0] SinReset = 16'sd0;

  typedef enum logic [1:0] {
    CfgCosBeta  = 2'd0,
    CfgSinBeta  = 2'd1,
    CfgCosAlpha = 2'd2,
    CfgSinAlpha = 2'd3
  } cfg_idx_e;

  // Upper bin of each weighting band, inclusive.
  localparam logic [BinW-1:0] BandTop [NumBands] = '{
    9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd7, 9'd9, 9'd12, 9'd15, 9'd19, 9'd24,
    9'd31, 9'd35, 9'd48, 9'd60, 9'd77, 9'd96, 9'd121, 9'd153, 9'd193,
    9'd241, 9'd304, 9'd386
  };

  // Wk weights for the vertical axis, unsigned Q1.15.
  localparam logic [CoefW-1:0] WkTable [NumBands] = '{
    16'd32473, 16'd33161, 16'd33489, 16'd33554, 16'd33194, 16'd31916,
    16'd29196, 16'd25428, 16'd21201, 16'd16777, 16'd13402, 16'd10650,
    16'd8389, 16'd6521, 16'd5112, 16'd3867, 16'd2766, 16'd1858, 16'd1130,
    16'd596, 16'd318, 16'd166, 16'd84
  };

  // Wd weights for the horizontal axes, unsigned Q1.15.
  localparam logic [CoefW-1:0] WdTable [NumBands] = '{
    16'd33128, 16'd29164, 16'd21037, 16'd16777, 16'd13402, 16'd10584,
    16'd8290, 16'd6947, 16'd5276, 16'd4096, 16'd3277, 16'd2621, 16'd2071,
    16'd1619, 16'd1271, 16'd967, 16'd691, 16'd462, 16'd283, 16'd149,
    16'd80, 16'd41, 16'd21
  };

  typedef struct packed {
    logic        [BinW-1:0]  bin_index;
    logic signed [CompW-1:0] x_real;
    logic signed [CompW-1:0] x_imag;
    logic signed [CompW-1:0] y_real;
    logic signed [CompW-1:0] y_imag;
    logic signed [CompW-1:0] z_real;
    logic signed [CompW-1:0] z_imag;
  } in_beat_t;

  typedef struct packed {
    logic        [BinW-1:0]  out_bin;
    logic signed [CompW-1:0] wx_real;
    logic signed [CompW-1:0] wx_imag;
    logic signed [CompW-1:0] wy_real;
    logic signed [CompW-1:0] wy_imag;
    logic signed [CompW-1:0] wz_real;
    logic signed [CompW-1:0] wz_imag;
  } out_beat_t;

  // Rotation matrix; the top middle entry is always zero and is left out.
  typedef struct packed {
    logic signed [CoefW-1:0] m00;
    logic signed [CoefW-1:0] m02;
    logic signed [CoefW-1:0] m10;
    logic signed [CoefW-1:0] m11;
    logic signed [CoefW-1:0] m12;
    logic signed [CoefW-1:0] m20;
    logic signed [CoefW-1:0] m21;
    logic signed [CoefW-1:0] m22;
  } mat_t;

  // Rotated bin handed from the rotation pipe to the weighting pipe.
  typedef struct packed {
    logic        [BinW-1:0]  bin;
    logic                    pass;
    logic        [CoefW-1:0] wd;
    logic        [CoefW-1:0] wk;
    logic signed [CompW-1:0] x_re;
    logic signed [CompW-1:0] x_im;
    logic signed [CompW-1:0] y_re;
    logic signed [CompW-1:0] y_im;
    logic signed [CompW-1:0] z_re;
    logic signed [CompW-1:0] z_im;
  } rot_t;

  function automatic logic [BandW-1:0] band_idx(input logic [BinW-1:0] bin);
    logic [BandW-1:0] idx;
    idx = BandW'(NumBands - 1);
    for (int i = NumBands - 1; i >= 0; i--) begin
      if (bin <= BandTop[i]) idx = BandW'(i);
    end
    return idx;
  endfunction

  // A bin with no weighting band gets weight zero.
  function automatic logic in_band(input logic [BinW-1:0] bin);
    return (bin != '0) && (bin <= TopWeightedBin);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tsrw_matrix.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsrw_matrix
// Angle registers and the registered rotation matrix built from them.
// ----------------------------------------------------------------------------
module tsrw_matrix (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [1:0]                      cfg_idx_i,
  input  wire logic [tsrw_pkg::CoefW-1:0]      cfg_wdata_i,
  output tsrw_pkg::mat_t                       mat_o
);

  logic signed [tsrw_pkg::CoefW-1:0] cos_beta_q, sin_beta_q;
  logic signed [tsrw_pkg::CoefW-1:0] cos_alpha_q, sin_alpha_q;
  tsrw_pkg::mat_t mat_d, mat_q;

  // Round a Q2.30 product to Q1.15 (half up) and saturate.
  function automatic logic signed [15:0] q15_sat(input logic signed [32:0] p);
    logic signed [33:0] t;
    logic signed [18:0] s;
    t = {p[32], p} + 34'sd16384;
    s = t[33:15];
    if (s > 19'sd32767) return 16'sd32767;
    else if (s < -19'sd32768) return -16'sd32768;
    else return s[15:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_beta_q  <= tsrw_pkg::CosReset;
      sin_beta_q  <= tsrw_pkg::SinReset;
      cos_alpha_q <= tsrw_pkg::CosReset;
      sin_alpha_q <= tsrw_pkg::SinReset;
    end else if (cfg_we_i) begin
      case (tsrw_pkg::cfg_idx_e'(cfg_idx_i))
        tsrw_pkg::CfgCosBeta:  cos_beta_q  <= cfg_wdata_i;
        tsrw_pkg::CfgSinBeta:  sin_beta_q  <= cfg_wdata_i;
        tsrw_pkg::CfgCosAlpha: cos_alpha_q <= cfg_wdata_i;
        tsrw_pkg::CfgSinAlpha: sin_alpha_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic signed [31:0] p_sasb, p_sacb, p_casb, p_cacb;
    p_sasb = sin_alpha_q * sin_beta_q;
    p_sacb = sin_alpha_q * cos_beta_q;
    p_casb = cos_alpha_q * sin_beta_q;
    p_cacb = cos_alpha_q * cos_beta_q;
    mat_d.m00 = cos_beta_q;
    mat_d.m02 = sin_beta_q;
    mat_d.m10 = q15_sat({p_sasb[31], p_sasb});
    mat_d.m11 = cos_alpha_q;
    mat_d.m12 = q15_sat(-{p_sacb[31], p_sacb});
    mat_d.m20 = q15_sat(-{p_casb[31], p_casb});
    mat_d.m21 = sin_alpha_q;
    mat_d.m22 = q15_sat({p_cacb[31], p_cacb});
  end

  // A register write reaches the matrix through the angle register and then the matrix register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= '{m00: tsrw_pkg::CosReset, m02: tsrw_pkg::SinReset,
                 m10: '0, m11: tsrw_pkg::CosReset, m12: '0,
                 m20: '0, m21: tsrw_pkg::SinReset, m22: 16'sd32766};
    end else begin
      mat_q <= mat_d;
    end
  end

  assign mat_o = mat_q;

endmodule

`default_nettype wire

// ===== rtl/tsrw_rotate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsrw_rotate
// Three-stage rotation pipe: input register with band lookup, matrix
// products, then row sums with rounding and saturation to 24 bits.
// ----------------------------------------------------------------------------
module tsrw_rotate (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tsrw_pkg::mat_t     mat_i,
  input  wire logic               valid_i,
  output      logic               stall_o,
  input  wire tsrw_pkg::in_beat_t data_i,
  output      logic               valid_o,
  input  wire logic               stall_i,
  output tsrw_pkg::rot_t          data_o
);

  localparam int unsigned PW = tsrw_pkg::ProdW;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned CW = tsrw_pkg::CompW;

  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_ready, s2_ready, s3_ready;

  tsrw_pkg::in_beat_t             s1_beat_q;
  logic                           s1_pass_q;
  logic [tsrw_pkg::CoefW-1:0]     s1_wd_q, s1_wk_q;

  // Products per part (0 real, 1 imaginary): m00 m02 m10 m11 m12 m20 m21 m22.
  logic signed [PW-1:0]           s2_prod_d [2][8];
  logic signed [PW-1:0]           s2_prod_q [2][8];
  logic [tsrw_pkg::BinW-1:0]      s2_bin_q;
  logic                           s2_pass_q;
  logic [tsrw_pkg::CoefW-1:0]     s2_wd_q, s2_wk_q;

  logic signed [CW-1:0]           s3_rot_d [2][3];
  tsrw_pkg::rot_t                 s3_q;

  assign s3_ready = !s3_valid_q || !stall_i;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign stall_o  = !s1_ready;

  function automatic logic signed [CW-1:0] round_sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0]    t;
    logic signed [SW-16:0]   s;
    t = v + SW'(16384);
    s = t[SW-1:15];
    if (s > (SW-15)'(8388607)) return 24'sh7fffff;
    else if (s < -(SW-15)'(8388608)) return 24'sh800000;
    else return s[CW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  // Stage 1: register the beat and look up both weights for its band.
  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      s1_beat_q <= data_i;
      s1_pass_q <= (data_i.bin_index == '0);
      if (tsrw_pkg::in_band(data_i.bin_index)) begin
        s1_wd_q <= tsrw_pkg::WdTable[tsrw_pkg::band_idx(data_i.bin_index)];
        s1_wk_q <= tsrw_pkg::WkTable[tsrw_pkg::band_idx(data_i.bin_index)];
      end else begin
        s1_wd_q <= '0;
        s1_wk_q <= '0;
      end
    end
  end

  // Stage 2: matrix entry times vector component.
  always_comb begin
    logic signed [CW-1:0] vx [2];
    logic signed [CW-1:0] vy [2];
    logic signed [CW-1:0] vz [2];
    vx[0] = s1_beat_q.x_real;  vx[1] = s1_beat_q.x_imag;
    vy[0] = s1_beat_q.y_real;  vy[1] = s1_beat_q.y_imag;
    vz[0] = s1_beat_q.z_real;  vz[1] = s1_beat_q.z_imag;
    for (int p = 0; p < 2; p++) begin
      s2_prod_d[p][0] = mat_i.m00 * vx[p];
      s2_prod_d[p][1] = mat_i.m02 * vz[p];
      s2_prod_d[p][2] = mat_i.m10 * vx[p];
      s2_prod_d[p][3] = mat_i.m11 * vy[p];
      s2_prod_d[p][4] = mat_i.m12 * vz[p];
      s2_prod_d[p][5] = mat_i.m20 * vx[p];
      s2_prod_d[p][6] = mat_i.m21 * vy[p];
      s2_prod_d[p][7] = mat_i.m22 * vz[p];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_prod_q <= s2_prod_d;
      s2_bin_q  <= s1_beat_q.bin_index;
      s2_pass_q <= s1_pass_q;
      s2_wd_q   <= s1_wd_q;
      s2_wk_q   <= s1_wk_q;
    end
  end

  // Stage 3: sum each row, round off the fraction and clamp.
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      s3_rot_d[p][0] = round_sat(SW'(s2_prod_q[p][0]) + SW'(s2_prod_q[p][1]));
      s3_rot_d[p][1] = round_sat(SW'(s2_prod_q[p][2]) + SW'(s2_prod_q[p][3])
                                 + SW'(s2_prod_q[p][4]));
      s3_rot_d[p][2] = round_sat(SW'(s2_prod_q[p][5]) + SW'(s2_prod_q[p][6])
                                 + SW'(s2_prod_q[p][7]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      s3_q.bin  <= s2_bin_q;
      s3_q.pass <= s2_pass_q;
      s3_q.wd   <= s2_wd_q;
      s3_q.wk   <= s2_wk_q;
      s3_q.x_re <= s3_rot_d[0][0];
      s3_q.x_im <= s3_rot_d[1][0];
      s3_q.y_re <= s3_rot_d[0][1];
      s3_q.y_im <= s3_rot_d[1][1];
      s3_q.z_re <= s3_rot_d[0][2];
      s3_q.z_im <= s3_rot_d[1][2];
    end
  end

  assign valid_o = s3_valid_q;
  assign data_o  = s3_q;

endmodule

`default_nettype wire

// ===== rtl/tsrw_weight.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsrw_weight
// Two-stage weighting pipe: weight products, then rounding, saturation
// and the bin zero bypass into the output register.
// ----------------------------------------------------------------------------
module tsrw_weight (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output      logic               stall_o,
  input  wire tsrw_pkg::rot_t     data_i,
  output      logic               valid_o,
  input  wire logic               stall_i,
  output tsrw_pkg::out_beat_t     data_o
);

  localparam int unsigned CW = tsrw_pkg::CompW;
  localparam int unsigned WW = CW + tsrw_pkg::CoefW + 1;

  logic s4_valid_q, s5_valid_q;
  logic s4_ready, s5_ready;

  logic signed [WW-1:0]       s4_prod_d [6];
  logic signed [WW-1:0]       s4_prod_q [6];
  logic signed [CW-1:0]       s4_rot_q  [6];
  logic [tsrw_pkg::BinW-1:0]  s4_bin_q;
  logic                       s4_pass_q;

  logic signed [CW-1:0]       s5_res_d [6];
  tsrw_pkg::out_beat_t        s5_q;

  assign s5_ready = !s5_valid_q || !stall_i;
  assign s4_ready = !s4_valid_q || s5_ready;
  assign stall_o  = !s4_ready;

  function automatic logic signed [CW-1:0] round_sat(input logic signed [WW-1:0] v);
    logic signed [WW-1:0]  t;
    logic signed [WW-16:0] s;
    t = v + WW'(16384);
    s = t[WW-1:15];
    if (s > (WW-15)'(8388607)) return 24'sh7fffff;
    else if (s < -(WW-15)'(8388608)) return 24'sh800000;
    else return s[CW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (s4_ready) s4_valid_q <= valid_i;
      if (s5_ready) s5_valid_q <= s4_valid_q;
    end
  end

  // Stage 4: component times unsigned weight (zero-extended to signed).
  always_comb begin
    logic signed [tsrw_pkg::CoefW:0] wd_s, wk_s;
    wd_s = {1'b0, data_i.wd};
    wk_s = {1'b0, data_i.wk};
    s4_prod_d[0] = data_i.x_re * wd_s;
    s4_prod_d[1] = data_i.x_im * wd_s;
    s4_prod_d[2] = data_i.y_re * wd_s;
    s4_prod_d[3] = data_i.y_im * wd_s;
    s4_prod_d[4] = data_i.z_re * wk_s;
    s4_prod_d[5] = data_i.z_im * wk_s;
  end

  always_ff @(posedge clk_i) begin
    if (s4_ready && valid_i) begin
      s4_prod_q   <= s4_prod_d;
      s4_rot_q[0] <= data_i.x_re;
      s4_rot_q[1] <= data_i.x_im;
      s4_rot_q[2] <= data_i.y_re;
      s4_rot_q[3] <= data_i.y_im;
      s4_rot_q[4] <= data_i.z_re;
      s4_rot_q[5] <= data_i.z_im;
      s4_bin_q    <= data_i.bin;
      s4_pass_q   <= data_i.pass;
    end
  end

  // Stage 5: bin zero leaves the rotated value unweighted.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      s5_res_d[k] = s4_pass_q ? s4_rot_q[k] : round_sat(s4_prod_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s5_ready && s4_valid_q) begin
      s5_q.out_bin <= s4_bin_q;
      s5_q.wx_real <= s5_res_d[0];
      s5_q.wx_imag <= s5_res_d[1];
      s5_q.wy_real <= s5_res_d[2];
      s5_q.wy_imag <= s5_res_d[3];
      s5_q.wz_real <= s5_res_d[4];
      s5_q.wz_imag <= s5_res_d[5];
    end
  end

  assign valid_o = s5_valid_q;
  assign data_o  = s5_q;

endmodule

`default_nettype wire

// ===== rtl/triaxial_spectrum_rotate_weight.sv =====
// Throughput: one beat per cycle; the five-stage multiply pipeline
// (band lookup, matrix products, row sums, weight products, rounding)
// takes a new beat every cycle unless the output side stalls.
// A register write reaches the matrix through the angle register and then the matrix register.
// Reset clears all valid bits and loads the identity tilt angles.
`default_nettype none
// ----------------------------------------------------------------------------
// triaxial_spectrum_rotate_weight
// Rotates one three-axis spectrum bin by two tilt angles and applies the
// whole-body Wd (x, y) and Wk (z) frequency weights by bin band.
// ----------------------------------------------------------------------------
module triaxial_spectrum_rotate_weight (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [tsrw_pkg::CoefW-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire tsrw_pkg::in_beat_t          in_data_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output tsrw_pkg::out_beat_t              out_data_o
);

  tsrw_pkg::mat_t mat;
  tsrw_pkg::rot_t rot_data;
  logic           rot_valid;
  logic           rot_stall;

  tsrw_matrix u_matrix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mat_o       (mat)
  );

  tsrw_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mat_i   (mat),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .valid_o (rot_valid),
    .stall_i (rot_stall),
    .data_o  (rot_data)
  );

  tsrw_weight u_weight (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_valid),
    .stall_o (rot_stall),
    .data_i  (rot_data),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

  // The input side only backs up when the output holds a stalled beat.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_stall_i && out_valid_o))
    else $error("input stall without a stalled output beat");

  // Bins above the top band carry zero weight on every axis.
  a_zero_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.out_bin > tsrw_pkg::TopWeightedBin)) |->
    (out_data_o.wx_real == '0 && out_data_o.wx_imag == '0 &&
     out_data_o.wy_real == '0 && out_data_o.wy_imag == '0 &&
     out_data_o.wz_real == '0 && out_data_o.wz_imag == '0))
    else $error("nonzero result for a bin above the top band");

  // A rotated beat stays valid while the weighting pipe is backed up.
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rot_valid && rot_stall) |=> rot_valid)
    else $error("rotated beat dropped while stalled");

endmodule

`default_nettype wire
